// ===== rtl/voxel_face_mesher_with_ao_assert.svh =====
`ifndef VOXEL_FACE_MESHER_WITH_AO_ASSERT_SVH
`define VOXEL_FACE_MESHER_WITH_AO_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VFM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VFM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vfm_pkg.sv =====
package vfm_pkg;

    localparam int COORD_BITS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NUM_FACES       = 6;
    localparam int COLOR_BITS      = 24;
    localparam int OCC_BITS        = 27;
    localparam int AO_BITS         = 8;
    localparam int VTX_BITS        = 32;
    localparam logic [VTX_BITS-1:0] VTX_PER_FACE = 32'd4;

    // face normal codes, in test order
    typedef enum logic [2:0] {
        FACE_NEG_X = 3'd0,
        FACE_POS_X = 3'd1,
        FACE_NEG_Y = 3'd2,
        FACE_POS_Y = 3'd3,
        FACE_NEG_Z = 3'd4,
        FACE_POS_Z = 3'd5
    } t_face;

    // classified voxel as it travels from front to back
    typedef struct packed {
        logic                                start;
        logic [NUM_FACES-1:0]                mask;
        logic [NUM_FACES-1:0][AO_BITS-1:0]   ao;
        logic [COLOR_BITS-1:0]               color;
    } t_face_info;

    // sample offsets along u and v for each ao bit
    localparam int AO_SU [AO_BITS] = '{-1, 1, 0, 0, -1, -1, 1, 1};
    localparam int AO_SV [AO_BITS] = '{0, 0, -1, 1, 1, -1, 1, -1};

    function automatic int next_axis(input int a);
        return (a == 2) ? 0 : a + 1;
    endfunction

    // normal component of face f on axis a
    function automatic int norm_axis(input int f, input int a);
        return (a == (f >> 1)) ? (((f & 1) != 0) ? 1 : -1) : 0;
    endfunction

    function automatic int tan_u(input int f, input int a);
        return norm_axis(f, next_axis(a));
    endfunction

    function automatic int tan_v(input int f, input int a);
        int t;
        t = norm_axis(f, next_axis(next_axis(a)));
        return ((f & 1) != 0) ? t : -t;
    endfunction

    function automatic int occ_index(input int dx, input int dy, input int dz);
        return (dx + 1) * 9 + (dy + 1) * 3 + (dz + 1);
    endfunction

    // occupancy bit of the neighbor across face f
    function automatic int face_bit(input int f);
        return occ_index(norm_axis(f, 0), norm_axis(f, 1), norm_axis(f, 2));
    endfunction

    // +1 per axis where u or v is negative, or along a positive normal
    function automatic logic [2:0] corner_off(input int f);
        logic [2:0] off;
        off = '0;
        for (int a = 0; a < 3; a++) begin
            off[a] = (tan_u(f, a) == -1) || (tan_v(f, a) == -1) || (norm_axis(f, a) > 0);
        end
        return off;
    endfunction

    function automatic logic [AO_BITS-1:0] ao_bits(input int f,
                                                   input logic [OCC_BITS-1:0] occ);
        logic [AO_BITS-1:0] code;
        int c [3];
        code = '0;
        for (int k = 0; k < AO_BITS; k++) begin
            for (int a = 0; a < 3; a++) begin
                c[a] = norm_axis(f, a) + AO_SU[k] * tan_u(f, a) + AO_SV[k] * tan_v(f, a);
            end
            code[k] = occ[occ_index(c[0], c[1], c[2])];
        end
        return code;
    endfunction

endpackage

// ===== rtl/vfm_front.sv =====
module vfm_front #(
    parameter int P_COORD_BITS = vfm_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_start,
    input  logic [P_COORD_BITS-1:0]       i_x,
    input  logic [P_COORD_BITS-1:0]       i_y,
    input  logic [P_COORD_BITS-1:0]       i_z,
    input  logic                          i_solid,
    input  logic [vfm_pkg::COLOR_BITS-1:0] i_color,
    input  logic [vfm_pkg::OCC_BITS-1:0]  i_occ,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [3*P_COORD_BITS-1:0]     o_pos,
    output vfm_pkg::t_face_info           o_info
);
    import vfm_pkg::*;

    logic                              r_valid;
    logic [3*P_COORD_BITS-1:0]         r_pos;
    t_face_info                        r_info;
    logic [NUM_FACES-1:0]              w_mask;
    logic [NUM_FACES-1:0][AO_BITS-1:0] w_ao;
    logic                              w_keep;
    logic                              w_accept;

    // exposed faces and their ao codes
    always_comb begin
        for (int f = 0; f < NUM_FACES; f++) begin
            w_mask[f] = i_solid & ~i_occ[face_bit(f)];
            w_ao[f]   = ao_bits(f, i_occ);
        end
    end

    // drop voxels that neither emit nor clear the counter
    assign w_keep   = i_start || (w_mask != '0);
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (w_accept && w_keep) || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos        <= {i_z, i_y, i_x};
            r_info.start <= i_start;
            r_info.mask  <= w_mask;
            r_info.ao    <= w_ao;
            r_info.color <= i_color;
        end
    end

    assign o_valid = r_valid;
    assign o_pos   = r_pos;
    assign o_info  = r_info;

endmodule

// ===== rtl/vfm_queue.sv =====
module vfm_queue #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = vfm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_valid,
    output logic               o_wr_ready,
    input  logic [P_WIDTH-1:0] i_wr_data,
    output logic               o_rd_valid,
    input  logic               i_rd_pop,
    output logic [P_WIDTH-1:0] o_rd_data
);
    import vfm_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_wr_ready = (r_count != CNT_W'(P_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = i_rd_pop && o_rd_valid;
    assign o_rd_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/vfm_back.sv =====
`include "voxel_face_mesher_with_ao_assert.svh"

module vfm_back #(
    parameter int P_COORD_BITS = vfm_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_head_valid,
    input  logic [3*P_COORD_BITS-1:0]      i_head_pos,
    input  vfm_pkg::t_face_info            i_head,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [3*P_COORD_BITS-1:0]      o_corner,
    output vfm_pkg::t_face                 o_normal,
    output logic [vfm_pkg::AO_BITS-1:0]    o_ao,
    output logic [vfm_pkg::COLOR_BITS-1:0] o_color,
    output logic [vfm_pkg::VTX_BITS-1:0]   o_first_vertex,
    output logic                           o_last
);
    import vfm_pkg::*;

    localparam int CB = P_COORD_BITS;

    logic [NUM_FACES-1:0]  r_done;
    logic [VTX_BITS-1:0]   r_cnt;
    logic                  r_out_valid;
    logic [3*CB-1:0]       r_corner;
    t_face                 r_normal;
    logic [AO_BITS-1:0]    r_ao;
    logic [COLOR_BITS-1:0] r_color;
    logic [VTX_BITS-1:0]   r_fv;
    logic                  r_last;

    logic [NUM_FACES-1:0]  w_pending;
    logic [NUM_FACES-1:0]  w_sel_hot;
    t_face                 w_sel;
    logic [2:0]            w_off;
    logic                  w_can_load;
    logic                  w_load;
    logic                  w_last;
    logic [VTX_BITS-1:0]   w_base;
    logic [3*CB-1:0]       w_corner;

    assign w_pending = i_head.mask & ~r_done;

    // lowest pending face first, matching the test order
    always_comb begin
        w_sel     = FACE_NEG_X;
        w_sel_hot = '0;
        w_off     = '0;
        for (int f = NUM_FACES - 1; f >= 0; f--) begin
            if (w_pending[f]) begin
                w_sel     = t_face'(f);
                w_sel_hot = NUM_FACES'(1) << f;
                w_off     = corner_off(f);
            end
        end
    end

    assign w_can_load = !r_out_valid || i_ready;
    assign w_load     = i_head_valid && w_can_load && (w_pending != '0);
    assign w_last     = ((w_pending & ~w_sel_hot) == '0);
    // start clears the counter before the voxel's first face
    assign w_base     = (i_head.start && (r_done == '0)) ? '0 : r_cnt;
    assign o_pop      = i_head_valid && ((w_pending == '0) || (w_load && w_last));

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_corner[a*CB +: CB] = i_head_pos[a*CB +: CB] + CB'(w_off[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_can_load) begin
                r_out_valid <= w_load;
            end
            if (o_pop) begin
                r_done <= '0;
            end else if (w_load) begin
                r_done <= r_done | w_sel_hot;
            end
            if (w_load) begin
                r_cnt <= w_base + VTX_PER_FACE;
            end else if (o_pop) begin
                r_cnt <= w_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_corner <= w_corner;
            r_normal <= w_sel;
            r_ao     <= i_head.ao[w_sel];
            r_color  <= i_head.color;
            r_fv     <= w_base;
            r_last   <= w_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_corner       = r_corner;
    assign o_normal       = r_normal;
    assign o_ao           = r_ao;
    assign o_color        = r_color;
    assign o_first_vertex = r_fv;
    assign o_last         = r_last;

    `VFM_ASSERT_IMP(a_pop_has_head, i_clk, i_rst_n, o_pop, i_head_valid, "pop from empty queue")
    `VFM_ASSERT_IMP(a_done_in_mask, i_clk, i_rst_n, i_head_valid, (r_done & ~i_head.mask) == '0, "emitted face not in mask")
    `VFM_ASSERT_NXT(a_cnt_step, i_clk, i_rst_n, w_load, r_cnt == $past(w_base) + VTX_PER_FACE, "vertex counter step wrong")

endmodule

// ===== rtl/voxel_face_mesher_with_ao.sv =====
// Voxel face mesher with ambient-occlusion codes. Each input item is one
// voxel with its 3x3x3 occupancy; every exposed face of a solid voxel comes
// out as one item, in the order -x, +x, -y, +y, -z, +z, with its quad corner,
// normal code, eight ao bits, color and first vertex index (a 32-bit counter
// that grows by 4 per face and is cleared by the start flag in tuser).
// tlast marks the last face of a voxel. Rate: the face sequencer emits one
// face per cycle while the receiver is ready, up to six per voxel; an empty
// or enclosed voxel that carries start still goes to the back end, one that
// does not is dropped in front. The front takes one voxel per cycle into a
// small queue while it has room, so input keeps flowing while faces drain.
// A voxel's first face passes the front register, queue and output register.
module voxel_face_mesher_with_ao #(
    parameter int P_COORD_BITS  = vfm_pkg::COORD_BITS_DEF,
    parameter int P_QUEUE_DEPTH = vfm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // voxel in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // voxel_x, voxel_y, voxel_z, is_solid, voxel_color, neighbor_occupancy, zero pad
    input  logic [((3*P_COORD_BITS+52+7)/8)*8-1:0] s_axis_tdata,
    // start_of_model
    input  logic [0:0]           s_axis_tuser,
    // face out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // corner_x, corner_y, corner_z, normal_code, ao_code, face_color, first_vertex, zero pad
    output logic [((3*P_COORD_BITS+67+7)/8)*8-1:0] m_axis_tdata,
    // last_face
    output logic                 m_axis_tlast
);
    import vfm_pkg::*;

    localparam int CB       = P_COORD_BITS;
    localparam int OUT_W    = ((3*P_COORD_BITS+67+7)/8)*8;
    localparam int Q_WIDTH  = 3*CB + $bits(t_face_info);

    // input field positions
    localparam int SOLID_LSB = 3*CB;
    localparam int COLOR_LSB = 3*CB + 1;
    localparam int OCC_LSB   = 3*CB + 1 + COLOR_BITS;

    // front to queue
    logic                  w_fr_valid;
    logic                  w_fr_ready;
    logic [3*CB-1:0]       w_fr_pos;
    t_face_info            w_fr_info;

    // queue to back
    logic                  w_q_valid;
    logic                  w_q_pop;
    logic [Q_WIDTH-1:0]    w_q_data;
    logic [3*CB-1:0]       w_head_pos;
    t_face_info            w_head_info;

    // back outputs
    logic [3*CB-1:0]       w_corner;
    t_face                 w_normal;
    logic [AO_BITS-1:0]    w_ao;
    logic [COLOR_BITS-1:0] w_color;
    logic [VTX_BITS-1:0]   w_fv;

    // front: classify faces and precompute ao codes
    vfm_front #(
        .P_COORD_BITS (P_COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_start (s_axis_tuser[0]),
        .i_x     (s_axis_tdata[0 +: CB]),
        .i_y     (s_axis_tdata[CB +: CB]),
        .i_z     (s_axis_tdata[2*CB +: CB]),
        .i_solid (s_axis_tdata[SOLID_LSB]),
        .i_color (s_axis_tdata[COLOR_LSB +: COLOR_BITS]),
        .i_occ   (s_axis_tdata[OCC_LSB +: OCC_BITS]),
        .o_valid (w_fr_valid),
        .i_ready (w_fr_ready),
        .o_pos   (w_fr_pos),
        .o_info  (w_fr_info)
    );

    // decoupling queue between classifier and face sequencer
    vfm_queue #(
        .P_WIDTH (Q_WIDTH),
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fr_valid),
        .o_wr_ready (w_fr_ready),
        .i_wr_data  ({w_fr_pos, w_fr_info}),
        .o_rd_valid (w_q_valid),
        .i_rd_pop   (w_q_pop),
        .o_rd_data  (w_q_data)
    );

    assign w_head_pos  = w_q_data[Q_WIDTH-1 -: 3*CB];
    assign w_head_info = t_face_info'(w_q_data[$bits(t_face_info)-1:0]);

    // back: one face per cycle while the output is ready, vertex counter, output register
    vfm_back #(
        .P_COORD_BITS (P_COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_q_valid),
        .i_head_pos     (w_head_pos),
        .i_head         (w_head_info),
        .o_pop          (w_q_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_corner       (w_corner),
        .o_normal       (w_normal),
        .o_ao           (w_ao),
        .o_color        (w_color),
        .o_first_vertex (w_fv),
        .o_last         (m_axis_tlast)
    );

    // pack result fields, lowest first, zero padded to bytes
    assign m_axis_tdata = OUT_W'({w_fv, w_color, w_ao, w_normal, w_corner});

endmodule

// ===== verif/voxel_face_mesher_with_ao_tb.sv =====
module voxel_face_mesher_with_ao_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vfm_pkg::*;

    localparam int CB       = COORD_BITS_DEF;
    localparam int S_W      = ((3*CB+52+7)/8)*8;
    localparam int M_W      = ((3*CB+67+7)/8)*8;
    localparam int LIMIT    = 200000;
    localparam int DRAIN    = 20;
    localparam logic [OCC_BITS-1:0] OCC_ALL = '1;

    // sample steps along u and v for ao bits 0..7
    localparam int STEP_U [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
    localparam int STEP_V [8] = '{0, 0, -1, 1, 1, -1, 1, -1};

    typedef struct {
        logic                  start;
        logic [CB-1:0]         pos [3];
        logic                  solid;
        logic [COLOR_BITS-1:0] color;
        logic [OCC_BITS-1:0]   occ;
    } t_voxel;

    typedef struct {
        logic [CB-1:0]         corner [3];
        t_face                 normal;
        logic [AO_BITS-1:0]    ao;
        logic [COLOR_BITS-1:0] color;
        logic [VTX_BITS-1:0]   first_vertex;
        logic                  last;
    } t_face_item;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // voxel_x, voxel_y, voxel_z, is_solid, voxel_color, neighbor_occupancy, zero pad
    logic [S_W-1:0]   s_axis_tdata = '0;
    // start_of_model
    logic [0:0]       s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // corner_x, corner_y, corner_z, normal_code, ao_code, face_color, first_vertex, zero pad
    logic [M_W-1:0]   m_axis_tdata;
    // last_face
    logic             m_axis_tlast;

    t_face_item       expected_faces [$];
    logic [VTX_BITS-1:0] vertex_total = '0;
    int               failures = 0;
    int               cycle_count = 0;
    int               sender_idle_pct = 0;
    int               stall_pct = 0;

    voxel_face_mesher_with_ao u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // neighbor solid at offset (dx,dy,dz); center and out-of-cube cells are empty
    function automatic logic neighbor_solid(logic [OCC_BITS-1:0] occ, int dx, int dy, int dz);
        if (dx < -1 || dx > 1 || dy < -1 || dy > 1 || dz < -1 || dz > 1)
            return 1'b0;
        if (dx == 0 && dy == 0 && dz == 0)
            return 1'b0;
        return occ[(dx + 1) * 9 + (dy + 1) * 3 + (dz + 1)];
    endfunction

    // work out the exposed faces of one voxel and queue them in emission order
    function automatic void predict_faces(t_voxel vx);
        t_face_item batch [$];
        t_face_item fc;
        int    n [3];
        int    u [3];
        int    v [3];
        int    probe [3];
        int    corner;
        if (vx.start)
            vertex_total = '0;
        if (!vx.solid)
            return;
        for (int f = 0; f < NUM_FACES; f++) begin
            for (int a = 0; a < 3; a++)
                n[a] = 0;
            n[f >> 1] = ((f & 1) != 0) ? 1 : -1;
            if (neighbor_solid(vx.occ, n[0], n[1], n[2]))
                continue;
            // u = (ny,nz,nx), v = (nz,nx,ny), v flipped for a negative normal
            for (int a = 0; a < 3; a++) begin
                u[a] = n[(a + 1) % 3];
                v[a] = ((f & 1) != 0) ? n[(a + 2) % 3] : -n[(a + 2) % 3];
            end
            for (int a = 0; a < 3; a++) begin
                corner = vx.pos[a];
                if (u[a] == -1 || v[a] == -1)
                    corner++;
                if (n[a] > 0)
                    corner++;
                fc.corner[a] = corner[CB-1:0];
            end
            fc.ao = '0;
            for (int k = 0; k < 8; k++) begin
                for (int a = 0; a < 3; a++)
                    probe[a] = n[a] + STEP_U[k] * u[a] + STEP_V[k] * v[a];
                fc.ao[k] = neighbor_solid(vx.occ, probe[0], probe[1], probe[2]);
            end
            fc.normal       = t_face'(f);
            fc.color        = vx.color;
            fc.first_vertex = vertex_total;
            fc.last         = 1'b0;
            vertex_total    = vertex_total + VTX_PER_FACE;
            batch = {batch, fc};
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_faces = {expected_faces, batch[i]};
    endfunction

    // face checker: every accepted item against the oldest expectation
    always @(posedge i_clk) begin : check_faces
        t_face_item want;
        t_face_item got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.corner[0]    = m_axis_tdata[CB-1:0];
            got.corner[1]    = m_axis_tdata[2*CB-1:CB];
            got.corner[2]    = m_axis_tdata[3*CB-1:2*CB];
            got.normal       = t_face'(m_axis_tdata[3*CB+2:3*CB]);
            got.ao           = m_axis_tdata[3*CB+10:3*CB+3];
            got.color        = m_axis_tdata[3*CB+34:3*CB+11];
            got.first_vertex = m_axis_tdata[3*CB+66:3*CB+35];
            got.last         = m_axis_tlast;
            if (expected_faces.size() == 0) begin
                $error("unexpected face item: normal %0d first_vertex %0d",
                       got.normal, got.first_vertex);
                failures++;
            end else begin
                want = expected_faces.pop_front();
                for (int a = 0; a < 3; a++) begin
                    if (got.corner[a] !== want.corner[a]) begin
                        $error("corner_%s: expected %0d, got %0d",
                               (a == 0) ? "x" : (a == 1) ? "y" : "z",
                               want.corner[a], got.corner[a]);
                        failures++;
                    end
                end
                if (got.normal !== want.normal) begin
                    $error("normal_code: expected %0d, got %0d", want.normal, got.normal);
                    failures++;
                end
                if (got.ao !== want.ao) begin
                    $error("ao_code: expected %h, got %h", want.ao, got.ao);
                    failures++;
                end
                if (got.color !== want.color) begin
                    $error("face_color: expected %h, got %h", want.color, got.color);
                    failures++;
                end
                if (got.first_vertex !== want.first_vertex) begin
                    $error("first_vertex: expected %0d, got %0d",
                           want.first_vertex, got.first_vertex);
                    failures++;
                end
                if (got.last !== want.last) begin
                    $error("last_face: expected %0d, got %0d", want.last, got.last);
                    failures++;
                end
            end
        end
    end

    // offer one voxel item, with random idle cycles ahead of it
    task automatic send_voxel(t_voxel vx);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= vx.start;
        s_axis_tdata  <= S_W'({vx.occ, vx.color, vx.solid, vx.pos[2], vx.pos[1], vx.pos[0]});
        predict_faces(vx);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_voxel make_voxel(logic start, int x, int y, int z, logic solid,
                                          logic [COLOR_BITS-1:0] color,
                                          logic [OCC_BITS-1:0] occ);
        t_voxel vx;
        vx.start  = start;
        vx.pos[0] = CB'(x);
        vx.pos[1] = CB'(y);
        vx.pos[2] = CB'(z);
        vx.solid  = solid;
        vx.color  = color;
        vx.occ    = occ;
        return vx;
    endfunction

    // occupancy bit of the neighbor across face f, written out per face
    function automatic int across_bit(int f);
        case (t_face'(f))
            FACE_NEG_X: return 4;
            FACE_POS_X: return 22;
            FACE_NEG_Y: return 10;
            FACE_POS_Y: return 16;
            FACE_NEG_Z: return 12;
            default:    return 14;
        endcase
    endfunction

    // each face alone, all six open, field extremes, checkerboard ao
    task automatic test_face_geometry();
        logic [OCC_BITS-1:0] occ;
        send_voxel(make_voxel(1'b1, 0, 0, 0, 1'b1, 24'h000000, '0));
        send_voxel(make_voxel(1'b0, 254, 254, 254, 1'b1, 24'hffffff, '0));
        for (int f = 0; f < NUM_FACES; f++) begin
            occ = OCC_ALL;
            occ[across_bit(f)] = 1'b0;
            send_voxel(make_voxel(1'b0, 17 * f + 1, 200 - 30 * f, 128 + f, 1'b1,
                                  24'h00ff00 << f, occ));
        end
        send_voxel(make_voxel(1'b0, 85, 170, 85, 1'b1, 24'h5a5a5a, 27'h5555555));
        send_voxel(make_voxel(1'b0, 170, 85, 170, 1'b1, 24'ha5a5a5, 27'h2aaaaaa));
        // center bit set must not matter
        send_voxel(make_voxel(1'b0, 127, 128, 129, 1'b1, 24'h123456, 27'h0002000));
    endtask

    task automatic test_special_cases();
        // start on an empty voxel still clears the counter
        send_voxel(make_voxel(1'b1, 10, 20, 30, 1'b0, 24'hffffff, '0));
        send_voxel(make_voxel(1'b0, 10, 20, 30, 1'b1, 24'h0000ff, '0));
        // fully enclosed voxel leaves the counter alone
        send_voxel(make_voxel(1'b0, 254, 0, 254, 1'b1, 24'hff0000, OCC_ALL));
        send_voxel(make_voxel(1'b0, 3, 4, 5, 1'b1, 24'h00ff00, 27'h7fbffff));
        // empty voxel without start is just dropped
        send_voxel(make_voxel(1'b0, 99, 99, 99, 1'b0, 24'h0f0f0f, 27'h1234567));
        // enclosed voxel carrying start
        send_voxel(make_voxel(1'b1, 1, 2, 3, 1'b1, 24'h808080, OCC_ALL));
        send_voxel(make_voxel(1'b0, 1, 2, 3, 1'b1, 24'h808080, 27'h4000001));
        // corners past the top of the grid wrap to zero
        send_voxel(make_voxel(1'b0, 255, 255, 255, 1'b1, 24'hc0ffee, '0));
    endtask

    function automatic t_voxel random_voxel();
        t_voxel vx;
        logic [OCC_BITS-1:0] a;
        logic [OCC_BITS-1:0] b;
        a = OCC_BITS'($urandom);
        b = OCC_BITS'($urandom);
        vx.start = ($urandom_range(0, 99) < 5);
        for (int i = 0; i < 3; i++)
            vx.pos[i] = CB'($urandom_range(0, 254));
        vx.solid = ($urandom_range(0, 99) < 88);
        vx.color = COLOR_BITS'($urandom);
        case ($urandom_range(0, 3))
            0: vx.occ = a;
            1: vx.occ = a | b;
            2: vx.occ = a & b;
            default: begin
                // buried voxel with a few faces opened up
                vx.occ = OCC_ALL;
                for (int f = 0; f < NUM_FACES; f++)
                    if ($urandom_range(0, 2) == 0)
                        vx.occ[across_bit(f)] = 1'b0;
                vx.occ = vx.occ & ~(a & b & ~OCC_BITS'(27'h0145400));
            end
        endcase
        return vx;
    endfunction

    task automatic run_random_phase(int idle, int stall, int items);
        sender_idle_pct = idle;
        stall_pct       = stall;
        repeat (items)
            send_voxel(random_voxel());
    endtask

    // random voxels through every mix of sender gaps and receiver stalls
    task automatic test_random_mesh();
        run_random_phase(0, 0, 35);
        run_random_phase(75, 0, 35);
        run_random_phase(0, 75, 35);
        run_random_phase(32, 32, 35);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_face_geometry();
        test_special_cases();
        test_random_mesh();
        s_axis_tvalid <= 1'b0;
        while (expected_faces.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
